@@ design/vtsp_pkg.sv @@
// Shared types and constants of the vertex projection engine.
package vtsp_pkg;

   localparam logic [1:0] CMD_LOAD_MV   = 2'd0;
   localparam logic [1:0] CMD_LOAD_PROJ = 2'd1;
   localparam logic [1:0] CMD_PROJECT   = 2'd2;

   localparam logic REG_SCREEN_WIDTH  = 1'b0;
   localparam logic REG_SCREEN_HEIGHT = 1'b1;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int SCREEN_BITS   = 13;
   localparam int PIX_BITS      = 16;
   localparam int PIX_POS_MAX   = 32767;
   localparam int PIX_NEG_MAG   = 32768;
   localparam int LANES         = 4;

   localparam logic [SCREEN_BITS-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [SCREEN_BITS-1:0] HEIGHT_RESET = 13'd480;

   typedef struct packed {
      logic clr;
      logic issue;
      logic accum;
   } lane_ctl_type;

endpackage

@@ design/vtsp_lane.sv @@
// One row lane: fixed-point multiply-accumulate of a matrix row with a vector.
module vtsp_lane #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  vtsp_pkg::lane_ctl_type      ctl,
   input  logic signed [WORD_BITS-1:0] coef,
   input  logic signed [WORD_BITS-1:0] vec,
   output logic signed [WORD_BITS-1:0] result
);

   localparam int PB = 2 * WORD_BITS;
   localparam int AB = WORD_BITS + 2;
   localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   logic signed [PB-1:0]        prod_ff;
   logic signed [PB-1:0]        prod_in;
   logic signed [AB-1:0]        acc_ff;
   logic signed [AB-1:0]        acc_in;
   logic signed [PB-1:0]        shifted;
   logic signed [WORD_BITS-1:0] term;

   always_comb begin
      prod_in = PB'(coef) * PB'(vec);
      shifted = prod_ff >>> FRAC_BITS;
      if ((shifted[PB-1:WORD_BITS-1] == '0) || (shifted[PB-1:WORD_BITS-1] == '1)) begin
         term = shifted[WORD_BITS-1:0];
      end else if (shifted[PB-1]) begin
         term = WMIN;
      end else begin
         term = WMAX;
      end
      acc_in = acc_ff + AB'(term);
      if ((acc_ff[AB-1:WORD_BITS-1] == '0) || (acc_ff[AB-1:WORD_BITS-1] == '1)) begin
         result = acc_ff[WORD_BITS-1:0];
      end else if (acc_ff[AB-1]) begin
         result = WMIN;
      end else begin
         result = WMAX;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.issue) begin
         prod_ff <= prod_in;
      end
      if (ctl.clr) begin
         acc_ff <= '0;
      end else if (ctl.accum) begin
         acc_ff <= acc_in;
      end
   end

endmodule

@@ design/vtsp_div.sv @@
// Bit-serial floor division with saturation to a signed 16-bit pixel.
module vtsp_div #(
   parameter int NB = 45,
   parameter int DB = 33
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic signed [NB:0]    num,
   input  logic signed [DB-1:0]  den,
   output logic                  done,
   output logic signed [vtsp_pkg::PIX_BITS-1:0] quot
);

   localparam int CB = $clog2(NB + 1);

   logic                  busy_ff;
   logic                  fin_ff;
   logic                  done_ff;
   logic                  neg_ff;
   logic [CB-1:0]         cnt_ff;
   logic [NB-1:0]         q_ff;
   logic [DB-1:0]         rem_ff;
   logic [DB-1:0]         d_ff;
   logic signed [vtsp_pkg::PIX_BITS-1:0] quot_ff;
   logic signed [vtsp_pkg::PIX_BITS-1:0] quot_in;
   logic [DB:0]           rem_t;
   logic                  ge;
   logic [DB-1:0]         rem_in;
   logic [NB:0]           mag1;
   logic [NB:0]           num_neg;
   logic [DB-1:0]         den_neg;

   always_comb begin
      rem_t   = {rem_ff, q_ff[NB-1]};
      ge      = rem_t >= {1'b0, d_ff};
      rem_in  = ge ? DB'(rem_t - {1'b0, d_ff}) : rem_t[DB-1:0];
      num_neg = -num;
      den_neg = -den;
      mag1    = {1'b0, q_ff} + (NB+1)'(rem_ff != '0);
      if (!neg_ff) begin
         quot_in = (q_ff > NB'(vtsp_pkg::PIX_POS_MAX)) ?
                   vtsp_pkg::PIX_BITS'(vtsp_pkg::PIX_POS_MAX) : q_ff[vtsp_pkg::PIX_BITS-1:0];
      end else if (mag1 > (NB+1)'(vtsp_pkg::PIX_NEG_MAG)) begin
         quot_in = {1'b1, {(vtsp_pkg::PIX_BITS-1){1'b0}}};
      end else begin
         quot_in = -mag1[vtsp_pkg::PIX_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         fin_ff  <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CB'(NB);
            neg_ff  <= num[NB] ^ den[DB-1];
            q_ff    <= num[NB] ? num_neg[NB-1:0] : num[NB-1:0];
            d_ff    <= den[DB-1] ? den_neg : den;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            q_ff   <= {q_ff[NB-2:0], ge};
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff - CB'(1);
            if (cnt_ff == CB'(1)) begin
               busy_ff <= 1'b0;
               fin_ff  <= 1'b1;
            end
         end else if (fin_ff) begin
            done_ff <= 1'b1;
            quot_ff <= quot_in;
         end
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

@@ design/vertex_to_screen_projection_top.sv @@
// Top level of the vertex projection engine: storage, sequencer, lanes and dividers.
// Usage of the vertex projection engine.
// The req_ channel carries one command item: a coefficient load for the
// model-view or projection matrix, or a point to project. Loads produce no
// result. A point item runs through four row lanes twice (model-view, then
// projection), and then through two bit-serial dividers working side by side,
// one quotient bit per cycle over WORD_BITS + 13 steps. The next item is taken
// only once the point's result has been written to the output register. A
// point with a zero w skips the dividers.
// The rsp_ channel carries one item per point: the screen position and a flag
// for a zero clip-space w. The result sits in an output register, so the next
// item is accepted while a result waits for the receiver; if the receiver
// stalls, a later point holds in its last stage until the register frees.
// Reset sets both matrices to identity and the viewport to 640 by 480.
// The csr_ port writes the viewport width at address 0 and height at 4.
module vertex_to_screen_projection_top #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_command,
   input  logic [3:0]          req_coeff_index,
   input  logic signed [31:0]  req_coeff_value,
   input  logic signed [31:0]  req_point_x,
   input  logic signed [31:0]  req_point_y,
   input  logic signed [31:0]  req_point_z,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [15:0]  rsp_screen_x,
   output logic signed [15:0]  rsp_screen_y,
   output logic                rsp_w_zero,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [vtsp_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [vtsp_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [vtsp_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                csr_pready
);

   localparam int WB  = WORD_BITS;
   localparam int EXT = (WORD_BITS > 32) ? WORD_BITS : 32;
   localparam int NB  = WORD_BITS + 13;
   localparam int DB  = WORD_BITS + 1;
   localparam int MB  = WORD_BITS + 15;
   localparam int SB  = vtsp_pkg::SCREEN_BITS;
   localparam logic signed [WB-1:0] WMAX = {1'b0, {(WB-1){1'b1}}};
   localparam logic signed [WB-1:0] WMIN = {1'b1, {(WB-1){1'b0}}};
   localparam logic signed [WB-1:0] ONE_W =
      (FRAC_BITS < WORD_BITS - 1) ? (WB'(1) << FRAC_BITS) : WMAX;
   localparam logic signed [EXT-1:0] IN_MAX = EXT'(WMAX);
   localparam logic signed [EXT-1:0] IN_MIN = EXT'(WMIN);

   typedef enum logic [2:0] {S_IDLE, S_MV, S_PJ, S_DIV, S_OUT} state_type;

   function automatic logic signed [WB-1:0] sat_in(input logic signed [31:0] v);
      logic signed [EXT-1:0] e;
      begin
         e = EXT'(v);
         if (e > IN_MAX) begin
            sat_in = WMAX;
         end else if (e < IN_MIN) begin
            sat_in = WMIN;
         end else begin
            sat_in = e[WB-1:0];
         end
      end
   endfunction

   state_type             state_ff;
   logic [2:0]            cnt_ff;
   logic signed [WB-1:0]  mv_ff [vtsp_pkg::LANES][4];
   logic signed [WB-1:0]  pj_ff [vtsp_pkg::LANES][4];
   logic signed [WB-1:0]  pt_ff [3];
   logic signed [WB-1:0]  cam_ff [vtsp_pkg::LANES];
   logic [SB-1:0]         width_ff;
   logic [SB-1:0]         height_ff;
   logic signed [15:0]    pend_x_ff;
   logic signed [15:0]    pend_y_ff;
   logic                  pend_wz_ff;
   logic                  rsp_valid_ff;
   logic signed [15:0]    rsp_x_ff;
   logic signed [15:0]    rsp_y_ff;
   logic                  rsp_wz_ff;

   vtsp_pkg::lane_ctl_type lane_ctl;
   logic signed [WB-1:0]  lane_coef [vtsp_pkg::LANES];
   logic signed [WB-1:0]  lane_res [vtsp_pkg::LANES];
   logic signed [WB-1:0]  vec;
   logic [1:0]            col;
   logic                  req_fire;
   logic                  csr_write;
   logic                  div_start;
   logic signed [WB:0]    sum_x;
   logic signed [WB:0]    sum_y;
   logic signed [MB-1:0]  prod_x;
   logic signed [MB-1:0]  prod_y;
   logic signed [DB-1:0]  den;
   logic                  dx_done;
   logic                  dy_done;
   logic signed [15:0]    dx_quot;
   logic signed [15:0]    dy_quot;

   always_comb begin
      col       = cnt_ff[1:0];
      req_ready = state_ff == S_IDLE;
      req_fire  = req_valid && req_ready;
      csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
      lane_ctl.clr   = cnt_ff == 3'd0;
      lane_ctl.issue = (state_ff == S_MV || state_ff == S_PJ) && !cnt_ff[2];
      lane_ctl.accum = (state_ff == S_MV || state_ff == S_PJ) && cnt_ff != 3'd0
                       && cnt_ff <= 3'd4;
      unique case (col)
         2'd0:    vec = (state_ff == S_MV) ? pt_ff[0] : cam_ff[0];
         2'd1:    vec = (state_ff == S_MV) ? pt_ff[1] : cam_ff[1];
         2'd2:    vec = (state_ff == S_MV) ? pt_ff[2] : cam_ff[2];
         default: vec = (state_ff == S_MV) ? ONE_W : cam_ff[3];
      endcase
      for (int i = 0; i < vtsp_pkg::LANES; i++) begin
         lane_coef[i] = (state_ff == S_MV) ? mv_ff[i][col] : pj_ff[i][col];
      end
      sum_x  = (WB+1)'(lane_res[3]) + (WB+1)'(lane_res[0]);
      sum_y  = (WB+1)'(lane_res[3]) - (WB+1)'(lane_res[1]);
      prod_x = MB'($signed({1'b0, width_ff})) * MB'(sum_x);
      prod_y = MB'($signed({1'b0, height_ff})) * MB'(sum_y);
      den    = {lane_res[3], 1'b0};
      div_start = (state_ff == S_PJ) && (cnt_ff == 3'd5) && (lane_res[3] != '0);
      csr_pready = 1'b1;
      csr_prdata = (csr_paddr[2] == vtsp_pkg::REG_SCREEN_HEIGHT) ?
                   vtsp_pkg::CSR_DATA_BITS'(height_ff) : vtsp_pkg::CSR_DATA_BITS'(width_ff);
   end

   for (genvar g = 0; g < vtsp_pkg::LANES; g++) begin : g_lane
      vtsp_lane #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_lane (
         .clock  (clock),
         .ctl    (lane_ctl),
         .coef   (lane_coef[g]),
         .vec    (vec),
         .result (lane_res[g])
      );
   end

   vtsp_div #(.NB(NB), .DB(DB)) u_div_x (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (prod_x[NB:0]),
      .den   (den),
      .done  (dx_done),
      .quot  (dx_quot)
   );

   vtsp_div #(.NB(NB), .DB(DB)) u_div_y (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (prod_y[NB:0]),
      .den   (den),
      .done  (dy_done),
      .quot  (dy_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         width_ff     <= vtsp_pkg::WIDTH_RESET;
         height_ff    <= vtsp_pkg::HEIGHT_RESET;
         for (int r = 0; r < vtsp_pkg::LANES; r++) begin
            for (int c = 0; c < 4; c++) begin
               mv_ff[r][c] <= (r == c) ? ONE_W : '0;
               pj_ff[r][c] <= (r == c) ? ONE_W : '0;
            end
         end
      end else begin
         if (csr_write) begin
            if (csr_paddr[2] == vtsp_pkg::REG_SCREEN_WIDTH) begin
               width_ff <= csr_pwdata[SB-1:0];
            end else begin
               height_ff <= csr_pwdata[SB-1:0];
            end
         end
         if (rsp_valid_ff && rsp_ready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               cnt_ff <= '0;
               if (req_fire) begin
                  unique case (req_command)
                     vtsp_pkg::CMD_LOAD_MV: begin
                        mv_ff[req_coeff_index[1:0]][req_coeff_index[3:2]] <=
                           sat_in(req_coeff_value);
                     end
                     vtsp_pkg::CMD_LOAD_PROJ: begin
                        pj_ff[req_coeff_index[1:0]][req_coeff_index[3:2]] <=
                           sat_in(req_coeff_value);
                     end
                     vtsp_pkg::CMD_PROJECT: begin
                        pt_ff[0] <= sat_in(req_point_x);
                        pt_ff[1] <= sat_in(req_point_y);
                        pt_ff[2] <= sat_in(req_point_z);
                        state_ff <= S_MV;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_MV: begin
               if (cnt_ff == 3'd5) begin
                  for (int i = 0; i < vtsp_pkg::LANES; i++) begin
                     cam_ff[i] <= lane_res[i];
                  end
                  cnt_ff   <= '0;
                  state_ff <= S_PJ;
               end else begin
                  cnt_ff <= cnt_ff + 3'd1;
               end
            end
            S_PJ: begin
               if (cnt_ff == 3'd5) begin
                  cnt_ff <= '0;
                  if (lane_res[3] == '0) begin
                     pend_x_ff  <= '0;
                     pend_y_ff  <= '0;
                     pend_wz_ff <= 1'b1;
                     state_ff   <= S_OUT;
                  end else begin
                     state_ff <= S_DIV;
                  end
               end else begin
                  cnt_ff <= cnt_ff + 3'd1;
               end
            end
            S_DIV: begin
               if (dx_done) begin
                  pend_x_ff  <= dx_quot;
                  pend_y_ff  <= dy_quot;
                  pend_wz_ff <= 1'b0;
                  state_ff   <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_x_ff     <= pend_x_ff;
                  rsp_y_ff     <= pend_y_ff;
                  rsp_wz_ff    <= pend_wz_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_screen_x = rsp_x_ff;
   assign rsp_screen_y = rsp_y_ff;
   assign rsp_w_zero   = rsp_wz_ff;

   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      dx_done == dy_done) else $error("Dividers finished out of step.");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_OUT))
      else $error("Result raised outside the output state.");

   a_wzero_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_w_zero |-> rsp_screen_x == '0 && rsp_screen_y == '0)
      else $error("Zero w item carries a nonzero position.");

   a_idle_no_div: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !dx_done) else $error("Divider finished while idle.");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the vertex projection engine.
`timescale 1ns / 1ps
module testbench;

   typedef struct {
      logic [1:0]         command;
      logic [3:0]         coeff_index;
      logic signed [31:0] coeff_value;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
   } cmd_item_type;

   typedef struct {
      logic signed [15:0] screen_x;
      logic signed [15:0] screen_y;
      logic               w_zero;
   } pixel_type;

   localparam longint WMAX = 64'sd2147483647;
   localparam longint WMIN = -64'sd2147483648;
   localparam longint ONE  = 64'sd65536;
   localparam int     LIMIT_CYCLES = 1500000;
   localparam logic [1:0] CMD_SPARE = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_command = vtsp_pkg::CMD_LOAD_MV;
   logic [3:0] req_coeff_index = '0;
   logic signed [31:0] req_coeff_value = '0;
   logic signed [31:0] req_point_x = '0;
   logic signed [31:0] req_point_y = '0;
   logic signed [31:0] req_point_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_screen_x;
   logic signed [15:0] rsp_screen_y;
   logic rsp_w_zero;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [vtsp_pkg::CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [vtsp_pkg::CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [vtsp_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   cmd_item_type pending_cmds[$];
   pixel_type    expected_pixels[$];
   longint       mv_mat[16];
   longint       proj_mat[16];
   longint       view_w;
   longint       view_h;
   int           send_idle_pct = 29;
   int           recv_idle_pct = 72;
   int           errors = 0;
   int           cycles = 0;

   vertex_to_screen_projection_top dut (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT_CYCLES) begin
         $display("FAIL vertex_to_screen_projection_top");
         $finish;
      end
   end

   function automatic void queue_cmd(cmd_item_type it);
      pending_cmds.insert(pending_cmds.size(), it);
   endfunction

   function automatic longint sat_word(longint v);
      if (v > WMAX) return WMAX;
      if (v < WMIN) return WMIN;
      return v;
   endfunction

   function automatic longint fx_product(longint a, longint b);
      logic signed [127:0] p;
      p = (128'(signed'(a)) * 128'(signed'(b))) >>> 16;
      if (p > WMAX) return WMAX;
      if (p < WMIN) return WMIN;
      return longint'(p);
   endfunction

   function automatic void transform(input longint m[16], input longint v[4],
                                     output longint r[4]);
      longint s;
      for (int i = 0; i < 4; i++) begin
         s = 0;
         for (int j = 0; j < 4; j++) s += fx_product(m[i + 4 * j], v[j]);
         r[i] = sat_word(s);
      end
   endfunction

   function automatic logic signed [15:0] to_pixel(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && ((n < 0) != (d < 0))) q -= 1;
      if (q > vtsp_pkg::PIX_POS_MAX) q = vtsp_pkg::PIX_POS_MAX;
      if (q < -vtsp_pkg::PIX_NEG_MAG) q = -vtsp_pkg::PIX_NEG_MAG;
      return 16'(q);
   endfunction

   function automatic void predict_projection(cmd_item_type it);
      longint pt[4], cam[4], clip[4];
      pixel_type px;
      case (it.command)
         vtsp_pkg::CMD_LOAD_MV: mv_mat[it.coeff_index] = longint'(it.coeff_value);
         vtsp_pkg::CMD_LOAD_PROJ: proj_mat[it.coeff_index] = longint'(it.coeff_value);
         vtsp_pkg::CMD_PROJECT: begin
            pt[0] = it.point_x;
            pt[1] = it.point_y;
            pt[2] = it.point_z;
            pt[3] = ONE;
            transform(mv_mat, pt, cam);
            transform(proj_mat, cam, clip);
            if (clip[3] == 0) begin
               px.screen_x = '0;
               px.screen_y = '0;
               px.w_zero = 1'b1;
            end else begin
               px.screen_x = to_pixel(view_w * (clip[3] + clip[0]), 2 * clip[3]);
               px.screen_y = to_pixel(view_h * (clip[3] - clip[1]), 2 * clip[3]);
               px.w_zero = 1'b0;
            end
            expected_pixels.insert(expected_pixels.size(), px);
         end
         default: ;
      endcase
   endfunction

   // A new item is presented only once the previous one has been accepted.
   always @(posedge clock) begin
      cmd_item_type nxt;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_projection(pending_cmds.pop_front());
         end
         if (!req_valid || req_ready) begin
            if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = pending_cmds[0];
               req_valid <= 1'b1;
               req_command <= nxt.command;
               req_coeff_index <= nxt.coeff_index;
               req_coeff_value <= nxt.coeff_value;
               req_point_x <= nxt.point_x;
               req_point_y <= nxt.point_y;
               req_point_z <= nxt.point_z;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      pixel_type exp_px;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected item x=%0d y=%0d wz=%0b", $time,
                        rsp_screen_x, rsp_screen_y, rsp_w_zero);
               errors++;
            end else begin
               exp_px = expected_pixels.pop_front();
               if (exp_px.screen_x !== rsp_screen_x || exp_px.screen_y !== rsp_screen_y ||
                   exp_px.w_zero !== rsp_w_zero) begin
                  $display("%0t: expected x=%0d y=%0d wz=%0b, got x=%0d y=%0d wz=%0b",
                           $time, exp_px.screen_x, exp_px.screen_y, exp_px.w_zero,
                           rsp_screen_x, rsp_screen_y, rsp_w_zero);
                  errors++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic logic signed [31:0] rand_word();
      case ($urandom_range(5))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return $urandom_range(0, 32'h7ffff);
         3: return -$signed({1'b0, 31'($urandom_range(0, 32'h7ffff))});
         default: return $urandom;
      endcase
   endfunction

   function automatic cmd_item_type make_item(logic [1:0] c, logic [3:0] idx,
                                              logic signed [31:0] v, logic signed [31:0] x,
                                              logic signed [31:0] y, logic signed [31:0] z);
      cmd_item_type it;
      it.command = c;
      it.coeff_index = idx;
      it.coeff_value = v;
      it.point_x = x;
      it.point_y = y;
      it.point_z = z;
      return it;
   endfunction

   task automatic write_viewport(logic reg_sel, logic [12:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= reg_sel ? vtsp_pkg::CSR_ADDR_BITS'(4) : vtsp_pkg::CSR_ADDR_BITS'(0);
      csr_pwdata <= {19'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (reg_sel == vtsp_pkg::REG_SCREEN_WIDTH) view_w = value;
      else view_h = value;
   endtask

   task automatic drain();
      wait (pending_cmds.size() == 0 && !req_valid && expected_pixels.size() == 0);
      repeat (80) @(posedge clock);
   endtask

   task automatic run_phase(int n);
      cmd_item_type it;
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 45) begin
            it = make_item(vtsp_pkg::CMD_PROJECT, 4'($urandom), $urandom, rand_word(),
                           rand_word(), rand_word());
            if ($urandom_range(3) == 0) begin
               it.point_x = $signed(32'($urandom_range(0, 20)) << 16) - 32'sd655360;
               it.point_y = $signed(32'($urandom_range(0, 20)) << 16) - 32'sd655360;
            end
         end else if (r < 55) begin
            it = make_item(vtsp_pkg::CMD_LOAD_PROJ, 4'd15, $urandom_range(0, 3) * 65536,
                           $urandom, $urandom, $urandom);
         end else if (r < 95) begin
            it = make_item($urandom_range(1) ? vtsp_pkg::CMD_LOAD_PROJ : vtsp_pkg::CMD_LOAD_MV,
                           4'($urandom), rand_word(), $urandom, $urandom, $urandom);
            if ($urandom_range(1)) it.coeff_value = $signed($urandom_range(0, 2 * 65536))
                                                    - 32'sd65536;
         end else begin
            it = make_item(CMD_SPARE, 4'($urandom), $urandom, $urandom, $urandom, $urandom);
         end
         queue_cmd(it);
      end
   endtask

   initial begin
      for (int i = 0; i < 16; i++) begin
         mv_mat[i] = (i % 5 == 0) ? ONE : 0;
         proj_mat[i] = (i % 5 == 0) ? ONE : 0;
      end
      view_w = vtsp_pkg::WIDTH_RESET;
      view_h = vtsp_pkg::HEIGHT_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      queue_cmd(make_item(vtsp_pkg::CMD_PROJECT, '0, '0, '0, '0, '0));
      queue_cmd(make_item(vtsp_pkg::CMD_PROJECT, 4'hf, 32'sh7fffffff, 32'sh7fffffff,
                          32'sh80000000, 32'sh7fffffff));
      queue_cmd(make_item(vtsp_pkg::CMD_PROJECT, '0, '0, 32'sh80000000, 32'sh7fffffff,
                          32'sh80000000));
      queue_cmd(make_item(vtsp_pkg::CMD_PROJECT, '0, '0, 32'sh00008000, -32'sh00008000,
                          32'sh00010000));
      queue_cmd(make_item(CMD_SPARE, 4'hf, 32'shffffffff, 32'shffffffff,
                          32'shffffffff, 32'shffffffff));
      queue_cmd(make_item(vtsp_pkg::CMD_LOAD_MV, 4'd14, 32'sh7fffffff, '0, '0, '0));
      queue_cmd(make_item(vtsp_pkg::CMD_PROJECT, '0, '0, 32'sh00010000, '0, 32'sh00020000));
      queue_cmd(make_item(vtsp_pkg::CMD_LOAD_MV, 4'd14, '0, '0, '0, '0));
      queue_cmd(make_item(vtsp_pkg::CMD_LOAD_PROJ, 4'd15, '0, '0, '0, '0));
      queue_cmd(make_item(vtsp_pkg::CMD_PROJECT, '0, '0, 32'sh00010000, 32'sh00010000, '0));
      queue_cmd(make_item(vtsp_pkg::CMD_LOAD_PROJ, 4'd11, 32'sh80000000, '0, '0, '0));
      queue_cmd(make_item(vtsp_pkg::CMD_PROJECT, '0, '0, '0, '0, -32'sh00010000));
      queue_cmd(make_item(vtsp_pkg::CMD_PROJECT, '0, '0, '0, '0, 32'sh00000001));
      queue_cmd(make_item(vtsp_pkg::CMD_LOAD_PROJ, 4'd11, '0, '0, '0, '0));
      queue_cmd(make_item(vtsp_pkg::CMD_LOAD_PROJ, 4'd15, 32'sh00010000, '0, '0, '0));
      drain();

      write_viewport(vtsp_pkg::REG_SCREEN_WIDTH, 13'd1);
      write_viewport(vtsp_pkg::REG_SCREEN_HEIGHT, 13'h1fff);
      run_phase(160);
      drain();
      write_viewport(vtsp_pkg::REG_SCREEN_WIDTH, 13'd4096);
      write_viewport(vtsp_pkg::REG_SCREEN_HEIGHT, 13'd0);
      run_phase(160);
      drain();
      send_idle_pct = 72;
      recv_idle_pct = 29;
      write_viewport(vtsp_pkg::REG_SCREEN_WIDTH, 13'h1fff);
      write_viewport(vtsp_pkg::REG_SCREEN_HEIGHT, 13'd1);
      run_phase(170);
      drain();
      write_viewport(vtsp_pkg::REG_SCREEN_WIDTH, 13'd1920);
      write_viewport(vtsp_pkg::REG_SCREEN_HEIGHT, 13'd1080);
      run_phase(170);
      drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_viewport(vtsp_pkg::REG_SCREEN_WIDTH, 13'($urandom_range(1, 4096)));
      write_viewport(vtsp_pkg::REG_SCREEN_HEIGHT, 13'($urandom_range(1, 4096)));
      run_phase(330);
      drain();

      if (errors == 0) $display("PASS vertex_to_screen_projection_top");
      else $display("FAIL vertex_to_screen_projection_top");
      $finish;
   end

endmodule
